FILE: sv/cfraw_pkg.sv
// shared types and constants for the directory extent lookup and record walker
// no dependencies
package cfraw_pkg;

    // request commands
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_NEXT    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // result status codes
    localparam logic [1:0] STS_ADDR    = 2'd0;
    localparam logic [1:0] STS_EOF     = 2'd1;
    localparam logic [1:0] STS_NO_FILE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_NAME_BASE = 2'd0;
    localparam logic [1:0] REG_NAME_EXT  = 2'd1;
    localparam logic [1:0] REG_USER      = 2'd2;
    localparam logic [1:0] REG_BASE_SEC  = 2'd3;

    // configuration reset values
    localparam logic [63:0] RST_NAME_BASE = 64'h2020_2020_2020_2020;
    localparam logic [23:0] RST_NAME_EXT  = 24'h20_2020;
    localparam logic [4:0]  RST_USER      = 5'd0;
    localparam logic [10:0] RST_BASE_SEC  = 11'd52;

    // directory entry layout
    localparam int          ENTRY_BYTES  = 32;
    localparam logic [4:0]  POS_USER     = 5'd0;
    localparam logic [4:0]  POS_NAME_LST = 5'd11;
    localparam logic [4:0]  POS_EXT_LO   = 5'd12;
    localparam logic [4:0]  POS_EXT_HI   = 5'd14;
    localparam logic [4:0]  POS_RCOUNT   = 5'd15;
    localparam logic [4:0]  POS_ALLOC    = 5'd16;
    localparam logic [4:0]  POS_LAST     = 5'd31;
    localparam logic [7:0]  USER_MAX     = 8'd31;

    // name character limits
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [6:0] CH_LC_LO  = 7'h60;
    localparam logic [6:0] CH_LC_HI  = 7'h7B;
    localparam logic [6:0] CH_PU_LO  = 7'h39;
    localparam logic [6:0] CH_PU_HI  = 7'h40;
    localparam logic [6:0] CH_DOT    = 7'h2E;
    localparam logic [6:0] CH_LBRK   = 7'h5B;
    localparam logic [6:0] CH_RBRK   = 7'h5D;

    localparam int TOTAL_W = 14;
    localparam int ADDR_W  = 12;

    typedef logic [6:0] t_char7;

    // legal name character
    function automatic logic name_char_ok(input logic [7:0] c);
        logic [6:0] s;
        s = c[6:0];
        name_char_ok = !((c < CH_SPACE) || ((s > CH_LC_LO) && (s < CH_LC_HI)) ||
                         ((s > CH_PU_LO) && (s < CH_PU_HI)) ||
                         (s == CH_DOT) || (s == CH_LBRK) || (s == CH_RBRK));
    endfunction

endpackage

FILE: sv/cpm_file_record_address_walker_core.sv
// directory extent lookup and sequential record address walker, top level
// slot tables in two synchronous memories; uses cfraw_pkg
// last entry byte: slot metadata read (S_TK_RD); on a match, rewrite (S_TK_WR) and block copy (S_TK_CP)
// next-record request: no file or end of file known at once is answered directly from idle, else slot
// check or search, then block read and address forming; one request at a time
// reset: synchronous active low, clears slot valid bits, counters and walk state;
// registers return to spaces, user 0, base sector 52; no clearing pass
module cpm_file_record_address_walker_core
    import cfraw_pkg::*;
#(
    parameter int SLOTS             = 64,
    parameter int BLOCKS_PER_EXTENT = 16,
    parameter int RECORDS_PER_BLOCK = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_dir_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [11:0] o_sector_address,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int SW  = $clog2(SLOTS);
    localparam int CBW = $clog2(BLOCKS_PER_EXTENT);
    localparam int BW  = $clog2(BLOCKS_PER_EXTENT + 1);
    localparam int RW  = $clog2(RECORDS_PER_BLOCK);
    localparam int BAW = $clog2(SLOTS * BLOCKS_PER_EXTENT);
    localparam int MW  = 8 + BW;
    localparam int SUMW = 24;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TK_RD = 4'd1;
    localparam logic [3:0] S_TK_WR = 4'd2;
    localparam logic [3:0] S_TK_CP = 4'd3;
    localparam logic [3:0] S_R_CHK = 4'd4;
    localparam logic [3:0] S_R_SRC = 4'd5;
    localparam logic [3:0] S_R_SRW = 4'd6;
    localparam logic [3:0] S_R_BLK = 4'd7;
    localparam logic [3:0] S_R_BLW = 4'd8;

    // configuration
    logic [63:0] r_tgt_base;
    logic [23:0] r_tgt_ext;
    logic [4:0]  r_tgt_user;
    logic [10:0] r_base_sec;

    // entry capture
    logic [4:0]    r_pos;
    logic [7:0]    r_user;
    t_char7        r_name [0:10];
    logic          r_name_ok;
    logic [4:0]    r_ext_lo;
    logic [7:0]    r_ext_hi;
    logic [7:0]    r_rcount;
    logic [7:0]    r_stage [0:BLOCKS_PER_EXTENT-1];
    logic [BW-1:0] r_nz;
    logic          r_nz_run;

    // walk state
    logic [3:0]         r_state;
    logic [SLOTS-1:0]   r_used;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] r_read;
    logic [SW:0]        r_cs;
    logic               r_active;
    logic [CBW-1:0]     r_cb;
    logic [RW-1:0]      r_rib;
    logic               r_closed;
    logic [BW-1:0]      r_cnt;
    logic [SW-1:0]      r_idx;
    logic [CBW-1:0]     r_k;

    // result register
    logic        r_ovalid;
    logic [1:0]  r_status;
    logic [11:0] r_addr;

    // memories
    logic [MW-1:0] mem_meta [0:SLOTS-1];
    logic [7:0]    mem_blk  [0:SLOTS*BLOCKS_PER_EXTENT-1];
    logic [MW-1:0] r_meta_q;
    logic [7:0]    r_blk_q;

    logic           in_acc;
    logic           entry_match;
    logic [12:0]    ext_idx;
    logic           meta_re;
    logic [SW-1:0]  meta_ra;
    logic           meta_we;
    logic [MW-1:0]  meta_wd;
    logic           blk_re;
    logic [BAW-1:0] blk_ra;
    logic           blk_we;
    logic [BAW-1:0] blk_wa;
    logic [7:0]     q_rc;
    logic [BW-1:0]  q_cnt;
    logic [SW-1:0]  act_slot;
    logic [4:0]     apos;
    logic [SUMW-1:0] addr_sum;

    assign o_in_ready = (r_state == S_IDLE) && (!r_ovalid || (i_command != CMD_NEXT));
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_out_valid      = r_ovalid;
    assign o_status         = r_status;
    assign o_sector_address = r_addr;

    assign q_rc     = r_meta_q[MW-1:BW];
    assign q_cnt    = r_meta_q[BW-1:0];
    assign act_slot = SW'(r_cs - (SW+1)'(1));
    assign apos     = r_pos - POS_ALLOC;
    assign ext_idx  = {r_ext_hi, r_ext_lo};

    // full entry match against the target
    always_comb begin
        entry_match = r_name_ok && (r_user <= USER_MAX) && (r_user == {3'd0, r_tgt_user});
        for (int i = 0; i < 8; i++) begin
            if (r_name[i] != r_tgt_base[56 - 8*i +: 7]) entry_match = 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            if (r_name[8 + i] != r_tgt_ext[16 - 8*i +: 7]) entry_match = 1'b0;
        end
    end

    // memory port selection
    always_comb begin
        meta_re = 1'b0;
        meta_ra = r_idx;
        blk_re  = 1'b0;
        blk_ra  = BAW'(act_slot * BLOCKS_PER_EXTENT) + BAW'(r_cb);
        if (r_state == S_TK_RD) begin
            meta_re = 1'b1;
            meta_ra = SW'(ext_idx);
        end else if (r_state == S_R_SRC) begin
            meta_re = 1'b1;
            meta_ra = SW'(r_cs);
        end else if (in_acc && (i_command == CMD_NEXT)) begin
            meta_re = 1'b1;
            meta_ra = act_slot;
        end
        if (r_state == S_R_BLK) blk_re = 1'b1;
        meta_we = (r_state == S_TK_WR);
        meta_wd = {r_rcount, r_nz};
        blk_we  = (r_state == S_TK_CP);
        blk_wa  = BAW'(r_idx * BLOCKS_PER_EXTENT) + BAW'(r_k);
    end

    assign addr_sum = SUMW'(r_base_sec) + SUMW'(r_blk_q) * SUMW'(RECORDS_PER_BLOCK)
                      + SUMW'(r_rib);

    // slot metadata memory
    always_ff @(posedge i_clk) begin
        if (meta_we) mem_meta[r_idx] <= meta_wd;
        if (meta_re) r_meta_q <= mem_meta[meta_ra];
    end

    // allocation block memory
    always_ff @(posedge i_clk) begin
        if (blk_we) mem_blk[blk_wa] <= r_stage[r_k];
        if (blk_re) r_blk_q <= mem_blk[blk_ra];
    end

    // entry capture, payload only
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_command == CMD_BYTE)) begin
            if (r_pos == POS_USER) r_user <= i_dir_byte;
            if ((r_pos != POS_USER) && (r_pos <= POS_NAME_LST))
                r_name[4'(r_pos - 5'd1)] <= i_dir_byte[6:0];
            if (r_pos == POS_EXT_LO) r_ext_lo <= i_dir_byte[4:0];
            if (r_pos == POS_EXT_HI) r_ext_hi <= i_dir_byte;
            if (r_pos == POS_RCOUNT) r_rcount <= i_dir_byte;
            if ((r_pos >= POS_ALLOC) && (32'(apos) < BLOCKS_PER_EXTENT))
                r_stage[CBW'(apos)] <= i_dir_byte;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_base <= RST_NAME_BASE;
            r_tgt_ext  <= RST_NAME_EXT;
            r_tgt_user <= RST_USER;
            r_base_sec <= RST_BASE_SEC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NAME_BASE: r_tgt_base <= i_cfg_data;
                REG_NAME_EXT:  r_tgt_ext  <= i_cfg_data[23:0];
                REG_USER:      r_tgt_user <= i_cfg_data[4:0];
                REG_BASE_SEC:  r_base_sec <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_name_ok <= 1'b1;
            r_nz      <= '0;
            r_nz_run  <= 1'b1;
            r_used    <= '0;
            r_total   <= '0;
            r_read    <= '0;
            r_cs      <= '0;
            r_active  <= 1'b0;
            r_cb      <= '0;
            r_rib     <= '0;
            r_closed  <= 1'b0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_k       <= '0;
            r_ovalid  <= 1'b0;
            r_status  <= STS_ADDR;
            r_addr    <= '0;
        end else begin
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_command)
                            CMD_BYTE: begin
                                r_pos <= r_pos + 5'd1;
                                // name legality and leading nonzero blocks on the fly
                                if (r_pos == POS_USER) begin
                                    r_name_ok <= 1'b1;
                                    r_nz      <= '0;
                                    r_nz_run  <= 1'b1;
                                end else if (r_pos <= POS_NAME_LST) begin
                                    if (!name_char_ok(i_dir_byte)) r_name_ok <= 1'b0;
                                end
                                if ((r_pos >= POS_ALLOC) && (32'(apos) < BLOCKS_PER_EXTENT)
                                    && r_nz_run) begin
                                    if (i_dir_byte != 8'd0) r_nz <= r_nz + BW'(1);
                                    else r_nz_run <= 1'b0;
                                end
                                if (r_pos == POS_LAST) r_state <= S_TK_RD;
                            end
                            CMD_NEXT: begin
                                if (r_closed || (r_total == '0)) begin
                                    r_ovalid <= 1'b1;
                                    r_status <= STS_NO_FILE;
                                    r_addr   <= '0;
                                end else if (r_read >= r_total) begin
                                    r_closed <= 1'b1;
                                    r_ovalid <= 1'b1;
                                    r_status <= STS_EOF;
                                    r_addr   <= '0;
                                end else if (r_active) begin
                                    r_state <= S_R_CHK;
                                end else begin
                                    r_state <= S_R_SRC;
                                end
                            end
                            CMD_RESTART: begin
                                r_pos    <= '0;
                                r_used   <= '0;
                                r_total  <= '0;
                                r_read   <= '0;
                                r_cs     <= '0;
                                r_active <= 1'b0;
                                r_cb     <= '0;
                                r_rib    <= '0;
                                r_closed <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                // entry complete: fetch old slot metadata, go on to update it if the entry matches
                S_TK_RD: begin
                    if (entry_match && (32'(ext_idx) < SLOTS)) begin
                        r_idx   <= SW'(ext_idx);
                        r_state <= S_TK_WR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                // correct total, write metadata
                S_TK_WR: begin
                    r_total <= r_total - (r_used[r_idx] ? TOTAL_W'(q_rc) : '0)
                               + TOTAL_W'(r_rcount);
                    r_used[r_idx] <= 1'b1;
                    r_k <= '0;
                    r_state <= (r_nz != '0) ? S_TK_CP : S_IDLE;
                end
                // copy staged blocks, one per cycle
                S_TK_CP: begin
                    r_k <= r_k + CBW'(1);
                    if ((BW'(r_k) + BW'(1)) >= r_nz) r_state <= S_IDLE;
                end
                // active slot may have shrunk
                S_R_CHK: begin
                    if ((r_cs == '0) || (BW'(r_cb) >= q_cnt)) begin
                        r_active <= 1'b0;
                        r_cb     <= '0;
                        r_rib    <= '0;
                        r_state  <= S_R_SRC;
                    end else begin
                        r_cnt   <= q_cnt;
                        r_state <= S_R_BLK;
                    end
                end
                // next used slot search
                S_R_SRC: begin
                    if (32'(r_cs) >= SLOTS) begin
                        r_closed <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_status <= STS_EOF;
                        r_addr   <= '0;
                        r_state  <= S_IDLE;
                    end else if (!r_used[SW'(r_cs)]) begin
                        r_cs <= r_cs + (SW+1)'(1);
                    end else begin
                        r_state <= S_R_SRW;
                    end
                end
                S_R_SRW: begin
                    r_cs <= r_cs + (SW+1)'(1);
                    if (q_cnt != '0) begin
                        r_active <= 1'b1;
                        r_cb     <= '0;
                        r_rib    <= '0;
                        r_cnt    <= q_cnt;
                        r_state  <= S_R_BLK;
                    end else begin
                        r_state <= S_R_SRC;
                    end
                end
                S_R_BLK: begin
                    r_state <= S_R_BLW;
                end
                // form sector address and advance the walk
                S_R_BLW: begin
                    r_ovalid <= 1'b1;
                    r_status <= STS_ADDR;
                    r_addr   <= addr_sum[ADDR_W-1:0];
                    r_read   <= r_read + TOTAL_W'(1);
                    if (((RW+1)'(r_rib) + (RW+1)'(1)) >= (RW+1)'(RECORDS_PER_BLOCK)) begin
                        r_rib <= '0;
                        if ((BW'(r_cb) + BW'(1)) >= r_cnt) begin
                            r_cb     <= '0;
                            r_active <= 1'b0;
                        end else begin
                            r_cb <= r_cb + CBW'(1);
                        end
                    end else begin
                        r_rib <= r_rib + RW'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/cfraw_checker.sv
// port-level checks for the record address walker
// bound to cpm_file_record_address_walker_core; uses cfraw_pkg
module cfraw_checker
    import cfraw_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_command,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [11:0] o_sector_address
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_sector_address))
        else $error("result changed while stalled");

    // status codes and zero address for non-address results
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STS_ADDR) ||
            ((o_status == STS_EOF || o_status == STS_NO_FILE) && o_sector_address == '0))
        else $error("bad status or address");

    // no new request for an address while a result is pending
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !(i_in_valid && o_in_ready && i_command == CMD_NEXT))
        else $error("request taken over pending result");

    // reset leaves no result behind
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind cpm_file_record_address_walker_core cfraw_checker u_cfraw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_command        (i_command),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_sector_address (o_sector_address)
);
